[hw/rtl/ipv4tv_pkg.sv]
// Package: shared types and constants for the IPv4 text validator.
package ipv4tv_pkg;

    localparam int TEXT_LIMIT_DEFAULT = 31;

    localparam int MIN_TEXT_LEN  = 7;
    localparam int TOKENS_NEEDED = 4;
    localparam int OCTET_MAX     = 255;
    localparam int TOKEN_SAT     = 256;
    localparam int LEN_OUT_MAX   = 31;
    localparam int TOKEN_CNT_MAX = 7;

    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_PRINT_LO  = 8'h20;
    localparam logic [7:0] CHAR_PRINT_HI  = 8'h7E;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_last;
    } in_item_t;

    typedef struct packed {
        logic       ip_valid;
        logic [4:0] text_length;
    } out_item_t;

    // Parse state apart from the character count, whose width follows the limit.
    typedef struct packed {
        logic       text_ended;
        logic [2:0] token_count;
        logic       in_token;
        logic [8:0] token_value;
        logic       format_bad;
    } parse_state_t;

endpackage

[hw/rtl/ipv4tv_step.sv]
// Per-byte parse update and end-of-frame verdict for the IPv4 text validator.
module ipv4tv_step #(
    parameter int TEXT_LIMIT = ipv4tv_pkg::TEXT_LIMIT_DEFAULT,
    parameter int CNT_W      = $clog2(TEXT_LIMIT + 1)
) (
    input  ipv4tv_pkg::in_item_t     item,
    input  ipv4tv_pkg::parse_state_t state,
    input  logic [CNT_W-1:0]         char_count,
    output ipv4tv_pkg::parse_state_t state_next,
    output logic [CNT_W-1:0]         char_count_next,
    output ipv4tv_pkg::out_item_t    result
);

    localparam int EXT_W = CNT_W + 5;

    logic                     printable;
    logic                     is_dot;
    logic                     is_digit;
    logic                     at_limit;
    logic [8:0]               base_value;
    logic [3:0]               digit;
    logic [11:0]              acc_value;
    ipv4tv_pkg::parse_state_t upd;
    logic [CNT_W-1:0]         upd_count;
    logic [3:0]               tokens;
    logic [EXT_W-1:0]         count_ext;

    always_comb
    begin
        printable  = (item.rx_byte >= ipv4tv_pkg::CHAR_PRINT_LO)
                  && (item.rx_byte <= ipv4tv_pkg::CHAR_PRINT_HI);
        is_dot     = (item.rx_byte == ipv4tv_pkg::CHAR_DOT);
        is_digit   = (item.rx_byte >= ipv4tv_pkg::CHAR_ZERO)
                  && (item.rx_byte <= ipv4tv_pkg::CHAR_NINE);
        at_limit   = ({1'b0, char_count} >= (CNT_W+1)'(TEXT_LIMIT));
        digit      = 4'(item.rx_byte - ipv4tv_pkg::CHAR_ZERO);
        base_value = state.in_token ? state.token_value : 9'd0;
        acc_value  = ({3'b0, base_value} * 12'd10) + {8'b0, digit};

        upd       = state;
        upd_count = char_count;
        if (!state.text_ended)
        begin
            if (!printable || at_limit)
            begin
                upd.text_ended = 1'b1;
            end
            else
            begin
                upd_count = char_count + CNT_W'(1);
                if (is_dot)
                begin
                    // Close an open token; empty tokens vanish.
                    if (state.in_token)
                    begin
                        if (state.token_count != 3'(ipv4tv_pkg::TOKEN_CNT_MAX))
                        begin
                            upd.token_count = state.token_count + 3'd1;
                        end
                        upd.in_token    = 1'b0;
                        upd.token_value = 9'd0;
                    end
                end
                else if (is_digit)
                begin
                    upd.in_token = 1'b1;
                    if (acc_value > 12'(ipv4tv_pkg::TOKEN_SAT))
                    begin
                        upd.token_value = 9'(ipv4tv_pkg::TOKEN_SAT);
                    end
                    else
                    begin
                        upd.token_value = acc_value[8:0];
                    end
                    if (acc_value > 12'(ipv4tv_pkg::OCTET_MAX))
                    begin
                        upd.format_bad = 1'b1;
                    end
                end
                else
                begin
                    upd.format_bad = 1'b1;
                end
            end
        end

        // Verdict from the updated state.
        tokens    = {1'b0, upd.token_count} + {3'b0, upd.in_token};
        count_ext = {5'b0, upd_count};
        result.ip_valid = !upd.format_bad
                       && (count_ext >= EXT_W'(ipv4tv_pkg::MIN_TEXT_LEN))
                       && (tokens == 4'(ipv4tv_pkg::TOKENS_NEEDED));
        if (count_ext > EXT_W'(ipv4tv_pkg::LEN_OUT_MAX))
        begin
            result.text_length = 5'(ipv4tv_pkg::LEN_OUT_MAX);
        end
        else
        begin
            result.text_length = count_ext[4:0];
        end

        // Drop all parse state once the frame closes.
        if (item.frame_last)
        begin
            state_next      = '0;
            char_count_next = '0;
        end
        else
        begin
            state_next      = upd;
            char_count_next = upd_count;
        end
    end

endmodule

[hw/rtl/ipv4_text_validator_top.sv]
// Top level of the IPv4 dotted-decimal text validator.
//
//  Channel  | Signals                           | Payload
//  ---------+-----------------------------------+----------------------------------
//  item     | item_valid, item_ready, item      | rx_byte[7:0], frame_last
//  result   | result_valid, result_ready,result | ip_valid, text_length[4:0]
//
// One byte is accepted per cycle while the input register can advance. A byte waits in
// the input register, then the parse update (one 9x4-bit multiply-add and compares)
// commits the state and, for the last byte of a frame, loads the result register, which
// raises result_valid. Reset (rst_n, async, active low) clears the parse state and both
// valid flags. A waiting result holds only the input register when it carries another
// last byte; ordinary bytes keep flowing while the result is stalled.
module ipv4_text_validator_top #(
    parameter int TEXT_LIMIT = ipv4tv_pkg::TEXT_LIMIT_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  ipv4tv_pkg::in_item_t  item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output ipv4tv_pkg::out_item_t result
);

    localparam int CNT_W = $clog2(TEXT_LIMIT + 1);

    // Input register
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    ipv4tv_pkg::in_item_t     s1_item_reg;

    // Parse state
    ipv4tv_pkg::parse_state_t state_reg;
    ipv4tv_pkg::parse_state_t state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    // Result register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    ipv4tv_pkg::out_item_t    out_item_reg;
    ipv4tv_pkg::out_item_t    step_result;

    logic                     s1_advance;
    logic                     accept;

    ipv4tv_step #(
        .TEXT_LIMIT (TEXT_LIMIT),
        .CNT_W      (CNT_W)
    ) u_step (
        .item            (s1_item_reg),
        .state           (state_reg),
        .char_count      (count_reg),
        .state_next      (state_next),
        .char_count_next (count_next),
        .result          (step_result)
    );

    // A last byte may only advance when the result register is free or draining.
    assign s1_advance = s1_valid_reg
                     && (!s1_item_reg.frame_last || !out_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || s1_advance;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
        if (s1_advance && s1_item_reg.frame_last)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (s1_advance && s1_item_reg.frame_last)
        begin
            out_item_reg <= step_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule
